[src/srcba_pkg.sv]
// Shared types and constants for the range-checked block averager.
// No dependencies; imported by every module of the block.
`default_nettype none

package srcba_pkg;

  localparam int TEMP_W   = 12;
  localparam int LEVEL_W  = 16;
  localparam int ERR_W    = 6;
  localparam int TSUM_W   = 17;
  localparam int LSUM_W   = 21;
  localparam int CNT_W    = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int DIV_SHIFT = 25;
  localparam int MULT_W   = DIV_SHIFT + 1;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_RST   = -12'sd500;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RST  = 12'sd1000;
  localparam logic [LEVEL_W-1:0]       LEVEL_LOW_RST  = 16'd400;
  localparam logic [LEVEL_W-1:0]       LEVEL_HIGH_RST = 16'd2500;
  localparam logic [ERR_W-1:0]         ERROR_CAP_RST  = 6'd50;

  typedef enum logic [2:0] {
    REG_TEMP_LOW   = 3'd0,
    REG_TEMP_HIGH  = 3'd1,
    REG_LEVEL_LOW  = 3'd2,
    REG_LEVEL_HIGH = 3'd3,
    REG_ERROR_CAP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_sample;
    logic [LEVEL_W-1:0]       level_sample;
    logic                     seed;
  } in_beat_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] avg_temp;
    logic [LEVEL_W-1:0]       avg_level;
    logic [ERR_W-1:0]         temp_errors;
    logic [ERR_W-1:0]         level_errors;
    logic                     avg_updated;
  } out_beat_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic [LEVEL_W-1:0]       level_low;
    logic [LEVEL_W-1:0]       level_high;
    logic [ERR_W-1:0]         error_cap;
  } cfg_t;

endpackage

`default_nettype wire

[src/srcba_cfg.sv]
// Configuration register bank behind an APB-style port.
// Depends on srcba_pkg for the register map and reset values.
`default_nettype none

module srcba_cfg
  import srcba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_low   <= TEMP_LOW_RST;
      cfg_r.temp_high  <= TEMP_HIGH_RST;
      cfg_r.level_low  <= LEVEL_LOW_RST;
      cfg_r.level_high <= LEVEL_HIGH_RST;
      cfg_r.error_cap  <= ERROR_CAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TEMP_LOW:   cfg_r.temp_low   <= pwdata[TEMP_W-1:0];
        REG_TEMP_HIGH:  cfg_r.temp_high  <= pwdata[TEMP_W-1:0];
        REG_LEVEL_LOW:  cfg_r.level_low  <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_HIGH: cfg_r.level_high <= pwdata[LEVEL_W-1:0];
        REG_ERROR_CAP:  cfg_r.error_cap  <= pwdata[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TEMP_LOW:   prdata = DATA_W'(cfg_r.temp_low);
      REG_TEMP_HIGH:  prdata = DATA_W'(cfg_r.temp_high);
      REG_LEVEL_LOW:  prdata = DATA_W'(cfg_r.level_low);
      REG_LEVEL_HIGH: prdata = DATA_W'(cfg_r.level_high);
      REG_ERROR_CAP:  prdata = DATA_W'(cfg_r.error_cap);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/srcba_core.sv]
// Window check, block accumulators, averages and error counters.
// Depends on srcba_pkg; state advances once per beat on step.
`default_nettype none

module srcba_core
  import srcba_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = 10
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_beat_t item,
  input  wire cfg_t     cfg,
  output out_beat_t     result
);

  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + BLOCK_LEN - 1) / BLOCK_LEN;
  localparam logic [MULT_W-1:0] MULT = MULT_W'(DIV_MULT);
  localparam logic [CNT_W:0]    LEN  = (CNT_W+1)'(BLOCK_LEN);
  localparam int PROD_W = LSUM_W + MULT_W;

  function automatic logic [LSUM_W-1:0] div_len(input logic [LSUM_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(MULT);
    return prod[DIV_SHIFT +: LSUM_W];
  endfunction

  logic signed [TSUM_W-1:0]  temp_sum_r, temp_sum_nxt, temp_sum_new;
  logic [LSUM_W-1:0]         level_sum_r, level_sum_nxt, level_sum_new;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [TEMP_W-1:0]  temp_avg_r, temp_avg_nxt;
  logic [LEVEL_W-1:0]        level_avg_r, level_avg_nxt;
  logic [ERR_W-1:0]          temp_err_r, temp_err_nxt;
  logic [ERR_W-1:0]          level_err_r, level_err_nxt;

  logic                      temp_ok, level_ok, block_done, updated;
  logic signed [TEMP_W-1:0]  temp_add, temp_q;
  logic [LEVEL_W-1:0]        level_add;
  logic [CNT_W:0]            cnt_inc;
  logic [TSUM_W-1:0]         temp_mag;
  logic [LSUM_W-1:0]         temp_q_mag, level_q;

  assign temp_ok  = (item.temp_sample < cfg.temp_high) && (item.temp_sample > cfg.temp_low);
  assign level_ok = (item.level_sample < cfg.level_high) &&
                    (item.level_sample >= cfg.level_low);

  assign temp_add      = temp_ok ? item.temp_sample : temp_avg_r;
  assign level_add     = level_ok ? item.level_sample : level_avg_r;
  assign temp_sum_new  = temp_sum_r + TSUM_W'(temp_add);
  assign level_sum_new = level_sum_r + LSUM_W'(level_add);
  assign cnt_inc       = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign block_done    = cnt_inc >= LEN;

  // divide magnitude, restore sign: truncation toward zero
  assign temp_mag   = temp_sum_new[TSUM_W-1] ? TSUM_W'(-temp_sum_new) : TSUM_W'(temp_sum_new);
  assign temp_q_mag = div_len(LSUM_W'(temp_mag));
  assign temp_q     = temp_sum_new[TSUM_W-1] ? -temp_q_mag[TEMP_W-1:0] : temp_q_mag[TEMP_W-1:0];
  assign level_q    = div_len(level_sum_new);

  always_comb begin
    temp_sum_nxt  = temp_sum_r;
    level_sum_nxt = level_sum_r;
    cnt_nxt       = cnt_r;
    temp_avg_nxt  = temp_avg_r;
    level_avg_nxt = level_avg_r;
    temp_err_nxt  = temp_err_r;
    level_err_nxt = level_err_r;
    updated       = 1'b0;
    if (item.seed) begin
      temp_avg_nxt  = item.temp_sample;
      level_avg_nxt = item.level_sample;
      updated       = 1'b1;
    end else begin
      if (temp_ok) begin
        temp_err_nxt = '0;
      end else if (temp_err_r < cfg.error_cap) begin
        temp_err_nxt = temp_err_r + ERR_W'(1);
      end
      if (level_ok) begin
        level_err_nxt = '0;
      end else if (level_err_r < cfg.error_cap) begin
        level_err_nxt = level_err_r + ERR_W'(1);
      end
      if (block_done) begin
        temp_avg_nxt  = temp_q;
        level_avg_nxt = level_q[LEVEL_W-1:0];
        temp_sum_nxt  = '0;
        level_sum_nxt = '0;
        cnt_nxt       = '0;
        updated       = 1'b1;
      end else begin
        temp_sum_nxt  = temp_sum_new;
        level_sum_nxt = level_sum_new;
        cnt_nxt       = cnt_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_sum_r  <= '0;
      level_sum_r <= '0;
      cnt_r       <= '0;
      temp_avg_r  <= '0;
      level_avg_r <= '0;
      temp_err_r  <= '0;
      level_err_r <= '0;
    end else if (step) begin
      temp_sum_r  <= temp_sum_nxt;
      level_sum_r <= level_sum_nxt;
      cnt_r       <= cnt_nxt;
      temp_avg_r  <= temp_avg_nxt;
      level_avg_r <= level_avg_nxt;
      temp_err_r  <= temp_err_nxt;
      level_err_r <= level_err_nxt;
    end
  end

  assign result.avg_temp     = temp_avg_nxt;
  assign result.avg_level    = level_avg_nxt;
  assign result.temp_errors  = temp_err_nxt;
  assign result.level_errors = level_err_nxt;
  assign result.avg_updated  = updated;

endmodule

`default_nettype wire

[src/sensor_range_check_block_average.sv]
// Top level: input register, averaging core, result register, config bank.
// Depends on srcba_pkg, srcba_cfg and srcba_core.
//
//   channel  ports                            direction  beat
//   in       in_valid/in_ready/in_data        sink       in_beat_t
//   out      out_valid/out_ready/out_data     source     out_beat_t
//   cfg      cfg_psel..cfg_pready (APB)       slave      32-bit register
//
// One beat per cycle sustained while out_ready holds; a beat passes the input and then the result register.
// The core's state updates as a beat moves from input to result register.
// A stalled result holds; the input register still takes one more beat.
// Synchronous active-low reset restores register defaults and clears state.
`default_nettype none

module sensor_range_check_block_average
  import srcba_pkg::*;
#(
  parameter int unsigned BLOCK_LEN = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  in_beat_t  in_r;
  logic      in_valid_r;
  out_beat_t out_r;
  logic      out_valid_r;
  out_beat_t result;
  cfg_t      cfg;
  logic      advance;

  srcba_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  srcba_core #(.BLOCK_LEN(BLOCK_LEN)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_r),
    .cfg    (cfg),
    .result (result)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  a_seed_updates: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.seed |=> out_valid && out_data.avg_updated)
    else $error("seed beat did not flag updated averages");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

  a_good_temp_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_r.seed && (in_r.temp_sample < cfg.temp_high) &&
    (in_r.temp_sample > cfg.temp_low) |=> out_data.temp_errors == '0)
    else $error("valid temperature did not clear its error count");

  a_seed_holds_errors: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.seed |-> result.temp_errors == $past(result.temp_errors) ||
    !$past(advance))
    else $error("seed beat changed an error count");

endmodule

`default_nettype wire

[tb/sensor_range_check_block_average_test.sv]
// Self-checking testbench for the range-checked block averager.
// Drives sensor beats and APB register writes, predicts every status beat
// and compares it field by field. Depends on srcba_pkg and the block's RTL.
module sensor_range_check_block_average_test;
  import srcba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_LEN    = 10;
  localparam int RANDOM_BEATS = 1300;
  localparam int IDLE_LIMIT   = 1000;
  localparam int NPLAN        = 32;
  localparam int BAD_PCT [5]  = '{0, 5, 30, 90, 100};

  typedef enum bit {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    reg_idx_t  idx;
    int        value;
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_beat_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_beat_t         out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  cfg_t regs = '{TEMP_LOW_RST, TEMP_HIGH_RST, LEVEL_LOW_RST, LEVEL_HIGH_RST, ERROR_CAP_RST};

  logic signed [TSUM_W-1:0] temp_acc = '0;
  logic [LSUM_W-1:0]        level_acc = '0;
  int                       readings_in_block = 0;
  logic signed [TEMP_W-1:0] temp_mean = '0;
  logic [LEVEL_W-1:0]       level_mean = '0;
  logic [ERR_W-1:0]         temp_run = '0;
  logic [ERR_W-1:0]         level_run = '0;

  out_beat_t pending_status [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        stalled = 0;
  bit        quiet = 1'b0;
  row_t      plan [NPLAN];

  sensor_range_check_block_average #(.BLOCK_LEN(BLOCK_LEN)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic out_beat_t next_status(input in_beat_t b);
    logic signed [TEMP_W-1:0] t;
    logic [LEVEL_W-1:0]       lv;
    logic                     upd;
    t   = b.temp_sample;
    lv  = b.level_sample;
    upd = 1'b0;
    if (b.seed) begin
      temp_mean  = t;
      level_mean = lv;
      upd        = 1'b1;
    end else begin
      if (t < regs.temp_high && t > regs.temp_low) begin
        temp_acc = temp_acc + t;
        temp_run = '0;
      end else begin
        temp_acc = temp_acc + temp_mean;
        if (temp_run < regs.error_cap) temp_run = temp_run + 1'b1;
      end
      if (lv < regs.level_high && lv >= regs.level_low) begin
        level_acc = level_acc + lv;
        level_run = '0;
      end else begin
        level_acc = level_acc + level_mean;
        if (level_run < regs.error_cap) level_run = level_run + 1'b1;
      end
      readings_in_block++;
      if (readings_in_block >= BLOCK_LEN) begin
        temp_mean         = TEMP_W'(temp_acc / BLOCK_LEN);
        level_mean        = LEVEL_W'(level_acc / BLOCK_LEN);
        temp_acc          = '0;
        level_acc         = '0;
        readings_in_block = 0;
        upd               = 1'b1;
      end
    end
    return '{temp_mean, level_mean, temp_run, level_run, upd};
  endfunction

  function automatic row_t drive(input int t, input int l, input bit s);
    row_t r;
    r.kind  = ROW_BEAT;
    r.idx   = REG_TEMP_LOW;
    r.value = 0;
    r.beat  = '{TEMP_W'(t), LEVEL_W'(l), s};
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t drive_exp(input int t, input int l, input bit s, input int at,
                                     input int al, input int te, input int le, input bit u);
    row_t r;
    r       = drive(t, l, s);
    r.typed = 1'b1;
    r.want  = '{TEMP_W'(at), LEVEL_W'(al), ERR_W'(te), ERR_W'(le), u};
    return r;
  endfunction

  function automatic row_t setreg(input reg_idx_t idx, input int v);
    row_t r;
    r       = drive(0, 0, 1'b0);
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.value = v;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value, input bit last);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_TEMP_LOW:   regs.temp_low   = value[TEMP_W-1:0];
      REG_TEMP_HIGH:  regs.temp_high  = value[TEMP_W-1:0];
      REG_LEVEL_LOW:  regs.level_low  = value[LEVEL_W-1:0];
      REG_LEVEL_HIGH: regs.level_high = value[LEVEL_W-1:0];
      default:        regs.error_cap  = value[ERR_W-1:0];
    endcase
    if (last) begin
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
    end
  endtask

  task automatic push_beat(input in_beat_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled <= 0;
    end else if (stalled == IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  initial begin : result_drain
    int        stall;
    out_beat_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_status.size() == 0) begin
        report($sformatf("status %0d arrived with nothing expected (%h)",
                         results_seen, out_data));
      end else begin
        want = pending_status.pop_front();
        if (out_data.avg_temp !== want.avg_temp)
          report($sformatf("status %0d avg_temp got %0d want %0d", results_seen,
                           $signed(out_data.avg_temp), $signed(want.avg_temp)));
        if (out_data.avg_level !== want.avg_level)
          report($sformatf("status %0d avg_level got %0d want %0d", results_seen,
                           out_data.avg_level, want.avg_level));
        if (out_data.temp_errors !== want.temp_errors)
          report($sformatf("status %0d temp_errors got %0d want %0d", results_seen,
                           out_data.temp_errors, want.temp_errors));
        if (out_data.level_errors !== want.level_errors)
          report($sformatf("status %0d level_errors got %0d want %0d", results_seen,
                           out_data.level_errors, want.level_errors));
        if (out_data.avg_updated !== want.avg_updated)
          report($sformatf("status %0d avg_updated got %0d want %0d", results_seen,
                           out_data.avg_updated, want.avg_updated));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int        sent;
    int        len;
    int        a;
    int        b;
    int        c;
    int        lo;
    int        hi;
    int        llo;
    int        lhi;
    int        t;
    int        lv;
    int        pick;
    int        tbad;
    int        lbad;
    int        seed_pct;
    bit        extreme;
    cfg_t      next_cfg;
    in_beat_t  beat;
    out_beat_t want;
    logic [DATA_W-1:0] value;

    plan = '{
      drive_exp(0, 1000, 0, 0, 0, 0, 0, 0),
      drive_exp(-2048, 0, 0, 0, 0, 1, 1, 0),
      drive_exp(2047, 65535, 0, 0, 0, 2, 2, 0),
      drive_exp(-500, 400, 0, 0, 0, 3, 0, 0),
      drive_exp(1000, 2500, 0, 0, 0, 4, 1, 0),
      drive_exp(-499, 2499, 0, 0, 0, 0, 0, 0),
      drive_exp(-2048, 65535, 1, -2048, 65535, 0, 0, 1),
      drive_exp(2047, 0, 1, 2047, 0, 0, 0, 1),
      drive(999, 2499, 0),
      drive(-1234, 100, 0),
      drive(500, 3000, 0),
      drive(1, 401, 0),
      setreg(REG_ERROR_CAP, 63),
      setreg(REG_TEMP_LOW, 2047),
      setreg(REG_LEVEL_LOW, 65535),
      drive(0, 1000, 0),
      drive(-1, 1500, 0),
      drive(7, 0, 0),
      drive(-2048, 2400, 0),
      setreg(REG_ERROR_CAP, 2),
      drive(100, 500, 0),
      drive(-100, 60000, 0),
      setreg(REG_ERROR_CAP, 0),
      setreg(REG_TEMP_LOW, -2048),
      setreg(REG_TEMP_HIGH, 2047),
      setreg(REG_LEVEL_LOW, 0),
      setreg(REG_LEVEL_HIGH, 65535),
      drive(-2047, 0, 0),
      drive(2046, 65534, 0),
      drive(-2048, 65535, 0),
      drive(-1, 32768, 1),
      drive(-1, 1, 0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NPLAN; i++) begin
      if (plan[i].kind == ROW_REG) begin
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        write_reg(plan[i].idx, DATA_W'(plan[i].value),
                  i + 1 == NPLAN || plan[i + 1].kind != ROW_REG);
      end else begin
        push_beat(plan[i].beat);
        want = next_status(plan[i].beat);
        pending_status.push_back(plan[i].typed ? plan[i].want : want);
      end
    end

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      in_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clk);
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: next_cfg = '{TEMP_LOW_RST, TEMP_HIGH_RST, LEVEL_LOW_RST, LEVEL_HIGH_RST,
                        ERROR_CAP_RST};
        1: next_cfg = '{-12'sd2048, 12'sd2047, 16'd0, 16'hFFFF,
                        ERR_W'($urandom_range(0, 1) * 63)};
        2: begin
          a = int'($urandom_range(0, 4095)) - 2048;
          b = int'($urandom_range(0, 4095)) - 2048;
          if (a > b) begin
            c = a; a = b; b = c;
          end
          next_cfg.temp_low  = TEMP_W'(a);
          next_cfg.temp_high = TEMP_W'(b);
          a = $urandom_range(0, 65535);
          b = $urandom_range(0, 65535);
          if (a > b) begin
            c = a; a = b; b = c;
          end
          next_cfg.level_low  = LEVEL_W'(a);
          next_cfg.level_high = LEVEL_W'(b);
          next_cfg.error_cap  = ERR_W'($urandom_range(0, 63));
        end
        default: next_cfg = cfg_t'(62'({$urandom, $urandom}));
      endcase
      for (int r = 0; r < 5; r++) begin
        case (reg_idx_t'(r))
          REG_TEMP_LOW:   value = DATA_W'(next_cfg.temp_low);
          REG_TEMP_HIGH:  value = DATA_W'(next_cfg.temp_high);
          REG_LEVEL_LOW:  value = DATA_W'(next_cfg.level_low);
          REG_LEVEL_HIGH: value = DATA_W'(next_cfg.level_high);
          default:        value = DATA_W'(next_cfg.error_cap);
        endcase
        write_reg(reg_idx_t'(r), value, r == 4);
      end

      lo       = regs.temp_low;
      hi       = regs.temp_high;
      llo      = regs.level_low;
      lhi      = regs.level_high;
      len      = $urandom_range(60, 200);
      tbad     = BAD_PCT[$urandom_range(0, 4)];
      lbad     = BAD_PCT[$urandom_range(0, 4)];
      seed_pct = $urandom_range(0, 8);
      extreme  = ($urandom_range(0, 4) == 0);
      repeat (len) begin
        if (extreme) begin
          pick = $urandom_range(0, 5);
          t = pick == 0 ? -2048 : pick == 1 ? 2047 : pick == 2 ? lo :
              pick == 3 ? lo + 1 : pick == 4 ? hi - 1 : hi;
          pick = $urandom_range(0, 5);
          lv = pick == 0 ? 0 : pick == 1 ? 65535 : pick == 2 ? llo :
               pick == 3 ? llo - 1 : pick == 4 ? lhi - 1 : lhi;
        end else begin
          if (int'($urandom_range(0, 99)) < tbad || hi - lo < 2)
            t = $urandom_range(0, 1) ? -2048 + int'($urandom_range(0, lo + 2048))
                                      : hi + int'($urandom_range(0, 2047 - hi));
          else
            t = lo + 1 + int'($urandom_range(0, hi - lo - 2));
          if (int'($urandom_range(0, 99)) < lbad || lhi <= llo)
            lv = (llo > 0 && $urandom_range(0, 1)) ? int'($urandom_range(0, llo - 1))
                                                   : int'($urandom_range(lhi, 65535));
          else
            lv = $urandom_range(llo, lhi - 1);
        end
        beat.temp_sample  = TEMP_W'(t);
        beat.level_sample = LEVEL_W'(lv);
        beat.seed         = (int'($urandom_range(0, 99)) < seed_pct);
        if ($urandom_range(0, 9) == 0) beat = in_beat_t'($bits(in_beat_t)'($urandom));
        push_beat(beat);
        pending_status.push_back(next_status(beat));
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
